[rtl/aimtb_pkg.sv]
// Shared sizes, payload types and codes of the adaptive mean threshold binarizer.
package aimtb_pkg;

   localparam int MAX_COLUMNS = 256;
   localparam int MAX_ROWS    = 256;
   localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;

   localparam int COL_W  = $clog2(MAX_COLUMNS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
   localparam int RCNT_W = $clog2(MAX_ROWS + 1);
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int POS_W  = $clog2(STORE_DEPTH + 1);

   localparam int PIX_W  = 16;
   localparam int INT_W  = 32;
   localparam int RSUM_W = 24;
   localparam int BIN_W  = 8;

   localparam int CSR_COLS_W = 9;
   localparam int CSR_ROWS_W = 9;
   localparam int CSR_WIN_W  = 10;
   localparam int CSR_FRAC_W = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int FRAC_W     = CSR_FRAC_W + 1;

   localparam int HALF_W   = CSR_WIN_W - 1;
   localparam int SPAN_MAX = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int SPAN_W   = ((SPAN_MAX > HALF_W) ? SPAN_MAX : HALF_W) + 1;
   localparam int AREA_W   = COL_W + ROW_W;
   localparam int LHS_W    = PIX_W + AREA_W;
   localparam int PROD_W   = INT_W + FRAC_W;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COLUMNS      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS         = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE        = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_FRACTION = 2'd3;

   localparam logic [CSR_COLS_W-1:0] COLS_RESET   = 9'd256;
   localparam logic [CSR_ROWS_W-1:0] ROWS_RESET   = 9'd256;
   localparam logic [CSR_WIN_W-1:0]  WIN_RESET    = 10'd32;
   localparam logic [CSR_FRAC_W-1:0] FRAC_RESET   = 16'd9830;

   localparam logic [BIN_W-1:0] BIN_DARK   = 8'd0;
   localparam logic [BIN_W-1:0] BIN_BRIGHT = 8'd255;

   typedef struct packed {
      logic             op;
      logic [PIX_W-1:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [BIN_W-1:0] binary_value;
      logic             last_pixel;
      logic             not_ready;
   } rsp_type;

   typedef struct packed {
      logic [COL_W-1:0] lx;
      logic [COL_W-1:0] rx;
      logic [ROW_W-1:0] ty;
      logic [ROW_W-1:0] by;
   } window_type;

endpackage

[rtl/adaptive_mean_threshold_binarizer.sv]
// Top level: frame loader, integral image builder and per-pixel threshold sequencer.
//
//  channel  | ports                              | moves
//  ---------+------------------------------------+-------------------------------
//  request  | req_valid req_ready req_data       | load one pixel or ask for one
//  result   | rsp_valid rsp_ready rsp_data       | one binarized pixel per ask
//  config   | csr_wr_en csr_index csr_wr_data    | register write, no handshake
//
// A load beat reads the integral entry one row up, then writes the new entry. A request beat
// walks the two-port integral memory (four corners in two reads) plus the multiply and compare
// steps; a request before the frame is complete goes straight to the result step. Reset is
// synchronous and needs no clearing pass. A pending result holds in the output register while
// the next beat is accepted; the sequencer waits in its last step only when that register is
// still full.
module adaptive_mean_threshold_binarizer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  aimtb_pkg::req_type             req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output aimtb_pkg::rsp_type             rsp_data,
   input  logic                           csr_wr_en,
   input  logic [aimtb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [aimtb_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import aimtb_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_LD_WR   = 3'd1;
   localparam logic [2:0] S_RQ_BASE = 3'd2;
   localparam logic [2:0] S_RQ_RD1  = 3'd3;
   localparam logic [2:0] S_RQ_RD2  = 3'd4;
   localparam logic [2:0] S_RQ_SUM  = 3'd5;
   localparam logic [2:0] S_RQ_CMP  = 3'd6;
   localparam logic [2:0] S_OUT     = 3'd7;

   function automatic logic [CNT_W-1:0] clamp_cols(input logic [CSR_COLS_W-1:0] raw);
      logic [CNT_W-1:0] r;
      if (raw == '0) begin
         r = CNT_W'(1);
      end else if (32'(raw) > 32'(MAX_COLUMNS)) begin
         r = CNT_W'(MAX_COLUMNS);
      end else begin
         r = CNT_W'(raw);
      end
      return r;
   endfunction

   function automatic logic [RCNT_W-1:0] clamp_rows(input logic [CSR_ROWS_W-1:0] raw);
      logic [RCNT_W-1:0] r;
      if (raw == '0) begin
         r = RCNT_W'(1);
      end else if (32'(raw) > 32'(MAX_ROWS)) begin
         r = RCNT_W'(MAX_ROWS);
      end else begin
         r = RCNT_W'(raw);
      end
      return r;
   endfunction

   // control registers
   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      cols_ff, cols_in;
   logic [RCNT_W-1:0]     rows_ff, rows_in;
   logic [CSR_WIN_W-1:0]  win_size_ff, win_size_in;
   logic [CSR_FRAC_W-1:0] frac_ff, frac_in;
   logic [RSUM_W-1:0]     rsum_ff, rsum_in;
   logic [ADDR_W-1:0]     load_pos_ff, load_pos_in;
   logic [COL_W-1:0]      load_col_ff, load_col_in;
   logic [ADDR_W-1:0]     read_pos_ff, read_pos_in;
   logic [COL_W-1:0]      read_col_ff, read_col_in;
   logic [ROW_W-1:0]      read_row_ff, read_row_in;
   logic                  loaded_ff, loaded_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [ADDR_W-1:0]     ld_addr_ff, ld_addr_in;
   logic [PIX_W-1:0]      ld_pix_ff, ld_pix_in;
   logic                  ld_above_ff, ld_above_in;
   window_type            win_ff, win_in;
   logic                  last_ff, last_in;
   logic [ADDR_W-1:0]     top_base_ff, top_base_in;
   logic [ADDR_W-1:0]     bot_base_ff, bot_base_in;
   logic [AREA_W-1:0]     area_ff, area_in;
   logic [PIX_W-1:0]      pix_ff, pix_in;
   logic [LHS_W-1:0]      lhs_ff, lhs_in;
   logic [INT_W-1:0]      box_ff, box_in;
   rsp_type               res_ff, res_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // datapath wiring
   logic [POS_W-1:0]      total;
   logic                  req_fire;
   logic [ADDR_W-1:0]     ld_pos;
   logic [COL_W-1:0]      ld_col;
   logic [POS_W-1:0]      ld_next;
   logic [POS_W-1:0]      rd_next;
   window_type            win_calc;
   logic [ADDR_W-1:0]     int_rd_a_addr;
   logic [ADDR_W-1:0]     int_rd_b_addr;
   logic [INT_W-1:0]      int_rd_a_data;
   logic [INT_W-1:0]      int_rd_b_data;
   logic                  int_wr_en;
   logic [INT_W-1:0]      int_wr_data;
   logic                  pix_rd_en;
   logic [PIX_W-1:0]      pix_rd_data;
   logic [FRAC_W-1:0]     keep_frac;
   logic [PROD_W-1:0]     rhs_prod;

   assign total     = POS_W'(cols_ff * rows_ff);
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a load after a complete frame starts over at position zero
   assign ld_pos  = loaded_ff ? '0 : load_pos_ff;
   assign ld_col  = loaded_ff ? '0 : load_col_ff;
   assign ld_next = POS_W'(ld_pos) + POS_W'(1);
   assign rd_next = POS_W'(read_pos_ff) + POS_W'(1);

   assign keep_frac = {1'b1, {CSR_FRAC_W{1'b0}}} - FRAC_W'(frac_ff);
   assign rhs_prod  = PROD_W'(box_ff) * PROD_W'(keep_frac);

   aimtb_window u_window (
      .px          (read_col_ff),
      .py          (read_row_ff),
      .cols        (cols_ff),
      .rows        (rows_ff),
      .window_size (win_size_ff),
      .win         (win_calc)
   );

   always_comb begin
      case (state_ff)
         S_RQ_RD1: begin
            int_rd_a_addr = ADDR_W'(bot_base_ff + ADDR_W'(win_ff.rx));
            int_rd_b_addr = ADDR_W'(top_base_ff + ADDR_W'(win_ff.rx));
         end
         S_RQ_RD2: begin
            int_rd_a_addr = ADDR_W'(bot_base_ff + ADDR_W'(win_ff.lx));
            int_rd_b_addr = ADDR_W'(top_base_ff + ADDR_W'(win_ff.lx));
         end
         default: begin
            // entry one row up from the pixel being loaded
            int_rd_a_addr = ADDR_W'(ld_pos - ADDR_W'(cols_ff));
            int_rd_b_addr = '0;
         end
      endcase
   end

   assign int_wr_en   = (state_ff == S_LD_WR);
   assign int_wr_data = (ld_above_ff ? int_rd_a_data : '0) + INT_W'(rsum_ff);
   assign pix_rd_en   = req_fire && (req_data.op == OP_READ);

   aimtb_integral_ram u_integral (
      .clock     (clock),
      .wr_en     (int_wr_en),
      .wr_addr   (ld_addr_ff),
      .wr_data   (int_wr_data),
      .rd_a_addr (int_rd_a_addr),
      .rd_a_data (int_rd_a_data),
      .rd_b_addr (int_rd_b_addr),
      .rd_b_data (int_rd_b_data)
   );

   aimtb_ram #(
      .DATA_W (PIX_W),
      .ADDR_W (ADDR_W)
   ) u_pixel (
      .clock   (clock),
      .wr_en   (int_wr_en),
      .wr_addr (ld_addr_ff),
      .wr_data (ld_pix_ff),
      .rd_en   (pix_rd_en),
      .rd_addr (read_pos_ff),
      .rd_data (pix_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      win_size_in  = win_size_ff;
      frac_in      = frac_ff;
      rsum_in      = rsum_ff;
      load_pos_in  = load_pos_ff;
      load_col_in  = load_col_ff;
      read_pos_in  = read_pos_ff;
      read_col_in  = read_col_ff;
      read_row_in  = read_row_ff;
      loaded_in    = loaded_ff;
      rsp_valid_in = rsp_valid_ff;
      ld_addr_in   = ld_addr_ff;
      ld_pix_in    = ld_pix_ff;
      ld_above_in  = ld_above_ff;
      win_in       = win_ff;
      last_in      = last_ff;
      top_base_in  = top_base_ff;
      bot_base_in  = bot_base_ff;
      area_in      = area_ff;
      pix_in       = pix_ff;
      lhs_in       = lhs_ff;
      box_in       = box_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;

      // drop the result once the beat is taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_data.op == OP_LOAD) begin
                  ld_addr_in  = ld_pos;
                  ld_pix_in   = req_data.pixel_value;
                  ld_above_in = (POS_W'(ld_pos) >= POS_W'(cols_ff));
                  rsum_in     = ((ld_col == '0) ? '0 : rsum_ff) + RSUM_W'(req_data.pixel_value);
                  if (loaded_ff) begin
                     read_pos_in = '0;
                     read_col_in = '0;
                     read_row_in = '0;
                  end
                  if (ld_next >= total) begin
                     loaded_in   = 1'b1;
                     load_pos_in = '0;
                     load_col_in = '0;
                  end else begin
                     loaded_in   = 1'b0;
                     load_pos_in = ADDR_W'(ld_next);
                     load_col_in = (CNT_W'(ld_col) + CNT_W'(1) == cols_ff) ? '0
                                                                           : COL_W'(ld_col + 1'b1);
                  end
                  state_in = S_LD_WR;
               end else if (!loaded_ff) begin
                  res_in.binary_value = BIN_DARK;
                  res_in.last_pixel   = 1'b0;
                  res_in.not_ready    = 1'b1;
                  state_in            = S_OUT;
               end else begin
                  win_in  = win_calc;
                  last_in = (rd_next >= total);
                  // advance the raster read position
                  if (rd_next >= total) begin
                     read_pos_in = '0;
                     read_col_in = '0;
                     read_row_in = '0;
                  end else begin
                     read_pos_in = ADDR_W'(rd_next);
                     if (CNT_W'(read_col_ff) + CNT_W'(1) == cols_ff) begin
                        read_col_in = '0;
                        read_row_in = ROW_W'(read_row_ff + 1'b1);
                     end else begin
                        read_col_in = COL_W'(read_col_ff + 1'b1);
                     end
                  end
                  state_in = S_RQ_BASE;
               end
            end
         end
         S_LD_WR: begin
            state_in = S_IDLE;
         end
         S_RQ_BASE: begin
            top_base_in = ADDR_W'(win_ff.ty * cols_ff);
            bot_base_in = ADDR_W'(win_ff.by * cols_ff);
            area_in     = AREA_W'((win_ff.rx - win_ff.lx) * (win_ff.by - win_ff.ty));
            pix_in      = pix_rd_data;
            state_in    = S_RQ_RD1;
         end
         S_RQ_RD1: begin
            lhs_in   = LHS_W'(pix_ff) * LHS_W'(area_ff);
            state_in = S_RQ_RD2;
         end
         S_RQ_RD2: begin
            box_in   = int_rd_a_data - int_rd_b_data;
            state_in = S_RQ_SUM;
         end
         S_RQ_SUM: begin
            box_in   = box_ff - int_rd_a_data + int_rd_b_data;
            state_in = S_RQ_CMP;
         end
         S_RQ_CMP: begin
            res_in.binary_value = (64'(lhs_ff) < 64'(rhs_prod[PROD_W-1:CSR_FRAC_W])) ? BIN_DARK
                                                                                    : BIN_BRIGHT;
            res_in.last_pixel   = last_ff;
            res_in.not_ready    = 1'b0;
            state_in            = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_COLUMNS: cols_in     = clamp_cols(csr_wr_data[CSR_COLS_W-1:0]);
            CSR_FRAME_ROWS:    rows_in     = clamp_rows(csr_wr_data[CSR_ROWS_W-1:0]);
            CSR_WINDOW_SIZE:   win_size_in = csr_wr_data[CSR_WIN_W-1:0];
            CSR_THRESHOLD_FRACTION: frac_in = csr_wr_data[CSR_FRAC_W-1:0];
            default: begin
            end
         endcase
         // a new frame size restarts the frame
         if (csr_index inside {CSR_FRAME_COLUMNS, CSR_FRAME_ROWS}) begin
            rsum_in     = '0;
            load_pos_in = '0;
            load_col_in = '0;
            read_pos_in = '0;
            read_col_in = '0;
            read_row_in = '0;
            loaded_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cols_ff      <= clamp_cols(COLS_RESET);
         rows_ff      <= clamp_rows(ROWS_RESET);
         win_size_ff  <= WIN_RESET;
         frac_ff      <= FRAC_RESET;
         rsum_ff      <= '0;
         load_pos_ff  <= '0;
         load_col_ff  <= '0;
         read_pos_ff  <= '0;
         read_col_ff  <= '0;
         read_row_ff  <= '0;
         loaded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         win_size_ff  <= win_size_in;
         frac_ff      <= frac_in;
         rsum_ff      <= rsum_in;
         load_pos_ff  <= load_pos_in;
         load_col_ff  <= load_col_in;
         read_pos_ff  <= read_pos_in;
         read_col_ff  <= read_col_in;
         read_row_ff  <= read_row_in;
         loaded_ff    <= loaded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ld_addr_ff  <= ld_addr_in;
      ld_pix_ff   <= ld_pix_in;
      ld_above_ff <= ld_above_in;
      win_ff      <= win_in;
      last_ff     <= last_in;
      top_base_ff <= top_base_in;
      bot_base_ff <= bot_base_in;
      area_ff     <= area_in;
      pix_ff      <= pix_in;
      lhs_ff      <= lhs_in;
      box_ff      <= box_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[rtl/aimtb_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
module aimtb_ram #(
   parameter int DATA_W = 16,
   parameter int ADDR_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/aimtb_integral_ram.sv]
// Integral image store: one write port and two registered read ports.
module aimtb_integral_ram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [aimtb_pkg::ADDR_W-1:0] wr_addr,
   input  logic [aimtb_pkg::INT_W-1:0]  wr_data,
   input  logic [aimtb_pkg::ADDR_W-1:0] rd_a_addr,
   output logic [aimtb_pkg::INT_W-1:0]  rd_a_data,
   input  logic [aimtb_pkg::ADDR_W-1:0] rd_b_addr,
   output logic [aimtb_pkg::INT_W-1:0]  rd_b_data
);
   import aimtb_pkg::*;

   logic [INT_W-1:0] mem [STORE_DEPTH];
   logic [INT_W-1:0] rd_a_ff;
   logic [INT_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

[rtl/aimtb_window.sv]
// Window clipping: corner coordinates of the averaging window around one pixel.
module aimtb_window (
   input  logic [aimtb_pkg::COL_W-1:0]     px,
   input  logic [aimtb_pkg::ROW_W-1:0]     py,
   input  logic [aimtb_pkg::CNT_W-1:0]     cols,
   input  logic [aimtb_pkg::RCNT_W-1:0]    rows,
   input  logic [aimtb_pkg::CSR_WIN_W-1:0] window_size,
   output aimtb_pkg::window_type           win
);
   import aimtb_pkg::*;

   logic [SPAN_W-1:0] half;
   logic [SPAN_W-1:0] px_w;
   logic [SPAN_W-1:0] py_w;
   logic [SPAN_W-1:0] right;
   logic [SPAN_W-1:0] bottom;
   logic [SPAN_W-1:0] col_lim;
   logic [SPAN_W-1:0] row_lim;

   always_comb begin
      half    = SPAN_W'(window_size[CSR_WIN_W-1:1]);
      px_w    = SPAN_W'(px);
      py_w    = SPAN_W'(py);
      right   = px_w + half;
      bottom  = py_w + half;
      col_lim = SPAN_W'(cols - CNT_W'(1));
      row_lim = SPAN_W'(rows - RCNT_W'(1));

      // clip each side to the frame
      win.lx = (px_w > half) ? COL_W'(px_w - half) : '0;
      win.ty = (py_w > half) ? ROW_W'(py_w - half) : '0;
      win.rx = (right < col_lim) ? COL_W'(right) : COL_W'(col_lim);
      win.by = (bottom < row_lim) ? ROW_W'(bottom) : ROW_W'(row_lim);
   end

endmodule
